// ===== sv/des_feistel_round_macros.svh =====
// ----------------------------------------------------------------------------
// DES Feistel round assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DES_FEISTEL_ROUND_MACROS_SVH
`define DES_FEISTEL_ROUND_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define DFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/desfr_pkg.sv =====
// ----------------------------------------------------------------------------
// DES Feistel round package
// Widths and the standard E, P and S tables.
// ----------------------------------------------------------------------------
package desfr_pkg;

	localparam int unsigned BLK_W  = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned KEY_W  = 48;

	typedef logic [BLK_W-1:0]  blk_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [5:0]        pos_t;   // table position, 1 = msb
	typedef logic [3:0]        nib_t;

	// Expansion: output bit i (from msb) takes input position E_TAB[i]
	localparam pos_t E_TAB [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
		6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
		6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
		6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
		6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam pos_t P_TAB [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	localparam nib_t SBOX_TAB [8][4][16] = '{
		'{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
		  '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
		  '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
		  '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
		'{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
		  '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
		  '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
		  '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
		'{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
		  '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
		  '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
		  '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
		'{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
		  '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
		  '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
		  '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
		'{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
		  '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
		  '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
		  '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
		'{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
		  '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
		  '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
		  '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
		'{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
		  '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
		  '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
		  '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
		'{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
		  '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
		  '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
		  '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
	};

endpackage

// ===== sv/desfr_f.sv =====
// ----------------------------------------------------------------------------
// DES round function
// f(R, K) = P(S(E(R) ^ K)), purely combinational.
// ----------------------------------------------------------------------------
module desfr_f (
	input  desfr_pkg::half_t right,
	input  desfr_pkg::key_t  key,
	output desfr_pkg::half_t f_out
);

	desfr_pkg::key_t  expanded;
	desfr_pkg::key_t  mixed;
	desfr_pkg::half_t subst;

	// expansion: position p (1 = msb) is bit 32 - p
	always_comb begin
		for (int i = 0; i < 48; i++) begin
			expanded[47 - i] = right[5'(6'd32 - desfr_pkg::E_TAB[i])];
		end
	end

	assign mixed = expanded ^ key;

	// eight S-boxes, S1 on the top group; row = outer bits, column = middle four
	always_comb begin
		logic [5:0] grp;
		grp = '0;
		for (int i = 0; i < 8; i++) begin
			grp = mixed[6*(7 - i) +: 6];
			subst[4*(7 - i) +: 4] = desfr_pkg::SBOX_TAB[i][{grp[5], grp[0]}][grp[4:1]];
		end
	end

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			f_out[31 - i] = subst[5'(6'd32 - desfr_pkg::P_TAB[i])];
		end
	end

endmodule

// ===== sv/des_feistel_round.sv =====
// ----------------------------------------------------------------------------
// DES Feistel round
// An accepted item passes the input reg, then the result reg, to result valid.
// Throughput one item per cycle unless result_ready stalls; the f path (E, S-boxes, P) sits between them.
// Reset clears both valid flags only; data registers are not reset.
// ----------------------------------------------------------------------------
`include "des_feistel_round_macros.svh"

module des_feistel_round (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                item_valid,
	output logic                item_ready,
	input  desfr_pkg::blk_t     block_in,
	input  desfr_pkg::key_t     round_key,
	// result channel
	output logic                result_valid,
	input  logic                result_ready,
	output desfr_pkg::blk_t     block_out
);

	// Stage 1: captured item
	logic             vld_s1;
	desfr_pkg::blk_t  blk_s1;
	desfr_pkg::key_t  key_s1;

	// Stage 2: finished result
	logic             vld_s2;
	desfr_pkg::blk_t  blk_s2;

	logic             adv_s2;    // stage 2 can take a new value
	logic             adv_s1;    // stage 1 can take a new item
	desfr_pkg::half_t f_val;

	// Ready ripples back from the output: each stage accepts when empty or
	// when its content moves on in the same cycle, so no bubbles under flow.
	assign adv_s2     = !vld_s2 || result_ready;
	assign adv_s1     = !vld_s1 || adv_s2;
	assign item_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			blk_s1 <= block_in;
			key_s1 <= round_key;
		end
	end

	// round function on the right half of the held item
	desfr_f u_f (
		.right (blk_s1[desfr_pkg::HALF_W-1:0]),
		.key   (key_s1),
		.f_out (f_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// left ^= f, right passes, halves not swapped
	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			blk_s2 <= {blk_s1[desfr_pkg::BLK_W-1:desfr_pkg::HALF_W] ^ f_val,
			           blk_s1[desfr_pkg::HALF_W-1:0]};
		end
	end

	assign result_valid = vld_s2;
	assign block_out    = blk_s2;

	// ---------------------------------------------------------------- checks
	// an empty result stage must never block the input
	`DFR_ASSERT_SAME(a_ready_when_out_empty, !result_valid, item_ready, "input blocked with empty output")

	// a held item stays put while the input is stalled
	`DFR_ASSERT_NEXT(a_s1_hold, vld_s1 && !item_ready, vld_s1 && $stable(blk_s1) && $stable(key_s1), "stalled item lost or changed")

	// an accepted item not stalled at the result stage emerges with its right half intact
	`DFR_ASSERT_NEXT(a_right_passes, (item_valid && item_ready) ##1 (!result_valid || result_ready), result_valid && (block_out[31:0] == $past(block_in[31:0], 2)), "right half not carried through")

endmodule

// ===== bench/tb_des_feistel_round.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DES Feistel round testbench
// Drives blocks and round keys through the valid/ready input channel, forms
// each expected block on the bench side from its own E, S and P tables, and
// checks results in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
package feistel_check_pkg;

	import desfr_pkg::blk_t;
	import desfr_pkg::half_t;
	import desfr_pkg::key_t;

	localparam int unsigned E_POS [48] = '{
		32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9,
		8, 9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
		16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
		24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1
	};

	localparam int unsigned P_POS [32] = '{
		16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
		2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
	};

	// one row per word, column 0 in the top nibble; S1 row 0 first
	localparam logic [63:0] S_ROWS [32] = '{
		64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
		64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
		64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5,
		64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
		64'hA09E63F51DC7B428, 64'hD709346A285ECBF1,
		64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
		64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9,
		64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
		64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986,
		64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
		64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38,
		64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
		64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86,
		64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
		64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92,
		64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
	};

	// one round: upper half gains f(lower, key), lower half unchanged, no swap
	function automatic blk_t feistel_round(blk_t blk, key_t key);
		half_t left;
		half_t right;
		half_t sbox_out;
		half_t f_out;
		logic [47:0] expanded;
		logic [5:0] grp;
		int row;
		int col;
		left  = blk[63:32];
		right = blk[31:0];
		for (int i = 0; i < 48; i++)
			expanded[47-i] = right[32-E_POS[i]];
		expanded = expanded ^ key;
		for (int g = 0; g < 8; g++) begin
			grp = expanded[47-6*g -: 6];
			row = {grp[5], grp[0]};
			col = grp[4:1];
			sbox_out[31-4*g -: 4] = S_ROWS[4*g+row][4*(15-col) +: 4];
		end
		for (int i = 0; i < 32; i++)
			f_out[31-i] = sbox_out[32-P_POS[i]];
		return {left ^ f_out, right};
	endfunction

	class round_scoreboard;
		blk_t want_blocks [$];
		int unsigned fails;

		function void note_item(blk_t blk, key_t key);
			want_blocks.push_back(feistel_round(blk, key));
		endfunction

		function void check_block(blk_t got);
			blk_t want;
			if (want_blocks.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result block_out=%h", got);
				return;
			end
			want = want_blocks.pop_front();
			if (got !== want) begin
				fails++;
				if (fails <= 10)
					$display("block_out mismatch: expected %h, got %h", want, got);
			end
		endfunction

		function int pending();
			return want_blocks.size();
		endfunction
	endclass

endpackage

module tb;

	import desfr_pkg::*;
	import feistel_check_pkg::*;

	localparam int unsigned STALL_LIMIT = 4000;   // cycles with no item moving
	localparam int unsigned RAND_BATCHES = 17;
	localparam int unsigned BATCH_ITEMS = 50;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  item_valid = 1'b0;
	logic  item_ready;
	blk_t  block_in = '0;
	key_t  round_key = '0;
	logic  result_valid;
	logic  result_ready = 1'b0;
	blk_t  block_out;

	// set for batches in which neither side idles
	bit    quiet = 1'b0;
	int unsigned stall_cycles = 0;

	round_scoreboard sb;

	des_feistel_round u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.block_in     (block_in),
		.round_key    (round_key),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.block_out    (block_out)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Half words biased towards the all-zero and all-one corners.
	function automatic half_t pick_half();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Present one item, then hold it until the handshake takes it. Valid is
	// left high on return so that a back-to-back item keeps it up.
	task automatic send_item(blk_t blk, key_t key);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		block_in   <= blk;
		round_key  <= key;
		do @(posedge clk); while (!item_ready);
		sb.note_item(blk, key);
	endtask

	// Hold the sender off until every outstanding result is back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Result side back-pressure: stall for a gap, then accept for a stretch.
	initial begin : ready_gen
		int n;
		int k;
		wait (arst_n === 1'b1);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			k = $urandom_range(1, 8);
			repeat (k) @(posedge clk);
		end
	end

	// Result monitor; values read here are those held at the clock edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_block(block_out);
	end

	// Watchdog: no item moving on either channel for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("des_feistel_round test failed");
			$finish;
		end
	end

	initial begin : stimulus
		half_t hi;
		half_t lo;
		half_t kx;
		sb = new;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners of both fields and the S-box row/column corners.
		send_item(64'h0, 48'h0);                          // row 0, column 0 everywhere
		send_item({64{1'b1}}, {48{1'b1}});
		send_item({64{1'b1}}, 48'h0);
		send_item(64'h0, {48{1'b1}});                     // row 3, column 15
		send_item(64'hAAAAAAAA_AAAAAAAA, 48'h555555555555);
		send_item(64'h55555555_55555555, 48'hAAAAAAAAAAAA);
		send_item(64'h0, 48'h820820820820);               // outer top bit only: row 2
		send_item(64'h0, 48'h041041041041);               // outer low bit only: row 1
		send_item(64'h0, 48'h3CF3CF3CF3CF);               // low column bits, row 1
		send_item(64'hFFFFFFFF_00000000, 48'h0);          // left half alone
		send_item(64'h00000000_FFFFFFFF, 48'h0);          // right half alone
		send_item(64'h01234567_89ABCDEF, 48'h1B02EFFC7072);
		// walking one across every fourth bit of the lower half, incl. the wrapped E position 32
		for (int i = 0; i < 32; i += 4)
			send_item({32'h0, 32'h1 << i}, 48'h0);
		send_item({32'h0, 32'h80000001}, {16'hFFFF, 32'hFFFFFFFF});

		// hold the sender until the pipe is empty
		wait_drained();

		// Random batches; some run without idling on either side.
		for (int b = 0; b < RAND_BATCHES; b++) begin
			quiet = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < BATCH_ITEMS; j++) begin
				hi = pick_half();
				lo = pick_half();
				kx = pick_half();
				send_item({hi, lo}, {kx[15:0], pick_half()});
			end
			if (b % 6 == 5)
				wait_drained();
		end
		quiet = 1'b0;

		item_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// let any stray result show up before judging
		repeat (8) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("des_feistel_round test passed");
		else
			$display("des_feistel_round test failed");
		$finish;
	end

endmodule
